// File: rtl/bvde_pkg.sv
// ----------------------------------------------------------------------------
// bvde_pkg
// Types, layout constants and status codes shared by the bulk voice dump
// extractor.
// ----------------------------------------------------------------------------
package bvde_pkg;

  localparam int VOICE_BYTES = 128;
  localparam int VOICE_COUNT = 32;

  localparam int HDR_LEN   = 6;
  localparam int DATA_LEN  = VOICE_BYTES * VOICE_COUNT;
  localparam int CHECK_POS = HDR_LEN + DATA_LEN;
  localparam int END_POS   = CHECK_POS + 1;
  localparam int DUMP_LEN  = END_POS + 1;
  localparam int POS_SAT   = DUMP_LEN + 1;

  localparam int POS_W    = 13;
  localparam int IDX_W    = $clog2(DATA_LEN);
  localparam int OFFSET_W = $clog2(VOICE_BYTES);
  localparam int SEL_W    = $clog2(VOICE_COUNT);
  localparam int SUM_W    = 7;

  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [7:0] SOX_BYTE    = 8'hF0;
  localparam logic [7:0] VENDOR_BYTE = 8'h43;
  localparam logic [7:0] TYPE_BYTE   = 8'h09;
  localparam logic [7:0] EOX_BYTE    = 8'hF7;

  localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_VENDOR = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(3);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SIZE     = 3'd1;
  localparam logic [2:0] ST_START    = 3'd2;
  localparam logic [2:0] ST_VENDOR   = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;
  localparam logic [2:0] ST_TYPE     = 3'd5;
  localparam logic [2:0] ST_CHECKSUM = 3'd6;

  typedef struct packed {
    logic [7:0] dump_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic                is_status;
    logic [7:0]          voice_byte;
    logic [OFFSET_W-1:0] voice_offset;
    logic [2:0]          status_code;
  } out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                is_status;
    logic [7:0]          dump_byte;
    logic [OFFSET_W-1:0] offset;
    logic                size_ok;
    logic                start_ok;
    logic                vendor_ok;
    logic                end_ok;
    logic                type_ok;
    logic                sum_ok;
  } cmd_t;

endpackage

// File: rtl/bulk_voice_dump_extractor_top.sv
// ----------------------------------------------------------------------------
// bulk_voice_dump_extractor_top
// Checks a 32-voice bulk dump byte stream and extracts the selected voice.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while full is low.
// Path: a result beat passes the command queue, then the output queue, before it
//   shows on the result ports; a full output queue holds it in the command queue.
// Reset: synchronous; clears both queues, the stream state and the held voice selection.
module bulk_voice_dump_extractor_top #(
  parameter int QUEUE_DEPTH = bvde_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bvde_pkg::in_t              dump_in,
  output logic                       full,
  output logic                       empty,
  input  logic                       pop,
  output bvde_pkg::out_t             result,
  input  logic                       voice_select_we,
  input  logic [bvde_pkg::SEL_W-1:0] voice_select
);
  import bvde_pkg::*;

  localparam int CMD_W = $bits(cmd_t);

  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_rdata;

  bvde_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .dump_in         (dump_in),
    .full            (full),
    .voice_select_we (voice_select_we),
    .voice_select    (voice_select),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in),
    .cmd_full        (cmd_full)
  );

  bvde_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  bvde_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_t'(cmd_rdata)),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// File: rtl/bvde_fifo.sv
// ----------------------------------------------------------------------------
// bvde_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module bvde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bvde_front.sv
// ----------------------------------------------------------------------------
// bvde_front
// Accepts dump bytes, tracks position, header flags and checksum, and
// queues voice data and status items for the back end.
// ----------------------------------------------------------------------------
module bvde_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bvde_pkg::in_t              dump_in,
  output logic                       full,
  input  logic                       voice_select_we,
  input  logic [bvde_pkg::SEL_W-1:0] voice_select,
  output logic                       cmd_push,
  output bvde_pkg::cmd_t             cmd,
  input  logic                       cmd_full
);
  import bvde_pkg::*;

  logic [SEL_W-1:0] voice_sel;
  logic [POS_W-1:0] byte_position;
  logic [SUM_W-1:0] running_sum;
  logic [7:0]       stored_check;
  logic [2:0]       header_flags;

  logic             accept;
  logic             last;
  logic [7:0]       b;
  logic [POS_W-1:0] rel_pos;
  logic [IDX_W-1:0] data_idx;
  logic             in_data;
  logic             hit;

  assign full     = cmd_full;
  assign accept   = push & ~cmd_full;
  assign b        = dump_in.dump_byte;
  assign last     = dump_in.final_byte;
  assign rel_pos  = byte_position - POS_W'(HDR_LEN);
  assign data_idx = rel_pos[IDX_W-1:0];
  assign in_data  = (byte_position >= POS_W'(HDR_LEN)) &&
                    (byte_position < POS_W'(CHECK_POS));
  assign hit      = in_data && (data_idx[IDX_W-1 -: SEL_W] == voice_sel);

  assign cmd_push = accept & (last | hit);

  always_comb begin
    cmd           = '0;
    cmd.is_status = last;
    if (last) begin
      cmd.size_ok   = (byte_position == POS_W'(END_POS));
      cmd.start_ok  = header_flags[0];
      cmd.vendor_ok = header_flags[1];
      cmd.end_ok    = (b == EOX_BYTE);
      cmd.type_ok   = header_flags[2];
      cmd.sum_ok    = (stored_check == {1'b0, running_sum});
    end else begin
      cmd.dump_byte = b;
      cmd.offset    = data_idx[OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_sel <= '0;
    end else if (voice_select_we) begin
      voice_sel <= voice_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      stored_check  <= '0;
      header_flags  <= '0;
    end else if (accept) begin
      if (last) begin
        // start a fresh dump on the next byte
        byte_position <= '0;
        running_sum   <= '0;
        stored_check  <= '0;
        header_flags  <= '0;
      end else begin
        if (byte_position == POS_START && b == SOX_BYTE) begin
          header_flags[0] <= 1'b1;
        end
        if (byte_position == POS_VENDOR && b == VENDOR_BYTE) begin
          header_flags[1] <= 1'b1;
        end
        if (byte_position == POS_TYPE && b == TYPE_BYTE) begin
          header_flags[2] <= 1'b1;
        end
        if (byte_position == POS_W'(CHECK_POS)) begin
          stored_check <= b;
        end
        if (in_data) begin
          running_sum <= running_sum - b[SUM_W-1:0];
        end
        // hold at saturation so a late flag reports a size error
        if (byte_position < POS_W'(POS_SAT)) begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/bvde_back.sv
// ----------------------------------------------------------------------------
// bvde_back
// Drains classified items, resolves the status code by check priority and
// formats result beats into the output queue.
// ----------------------------------------------------------------------------
module bvde_back #(
  parameter int QUEUE_DEPTH = bvde_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  bvde_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  logic           pop,
  output bvde_pkg::out_t result
);
  import bvde_pkg::*;

  localparam int OUT_W = $bits(out_t);

  logic             out_full;
  out_t             res;
  logic [OUT_W-1:0] out_rdata;

  assign cmd_pop = ~cmd_empty & ~out_full;

  always_comb begin
    res           = '0;
    res.is_status = cmd.is_status;
    if (cmd.is_status) begin
      // first failing check wins
      if (!cmd.size_ok) begin
        res.status_code = ST_SIZE;
      end else if (!cmd.start_ok) begin
        res.status_code = ST_START;
      end else if (!cmd.vendor_ok) begin
        res.status_code = ST_VENDOR;
      end else if (!cmd.end_ok) begin
        res.status_code = ST_END;
      end else if (!cmd.type_ok) begin
        res.status_code = ST_TYPE;
      end else if (!cmd.sum_ok) begin
        res.status_code = ST_CHECKSUM;
      end else begin
        res.status_code = ST_OK;
      end
    end else begin
      res.voice_byte   = cmd.dump_byte;
      res.voice_offset = cmd.offset;
    end
  end

  bvde_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_pop),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign result = out_t'(out_rdata);

endmodule

// File: rtl/bvde_checker.sv
// ----------------------------------------------------------------------------
// bvde_checker
// Port-level checks on the extractor result stream.
// ----------------------------------------------------------------------------
module bvde_checker (
  input logic           clk,
  input logic           rst,
  input logic           empty,
  input logic           pop,
  input bvde_pkg::out_t result
);
  import bvde_pkg::*;

  // reset drains both queues
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result beat changed");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_status) |->
      (result.voice_byte == 8'h00 && result.voice_offset == '0 &&
       result.status_code <= ST_CHECKSUM))
    else $error("status beat carries voice data");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.is_status) |-> (result.status_code == ST_OK))
    else $error("voice data beat carries a status code");

endmodule

bind bulk_voice_dump_extractor_top bvde_checker u_bvde_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bulk voice dump extractor. A short table of
// single bytes exercises the header, the first data bytes and early end
// flags. Full dumps then hit each status code and the saturated size case,
// followed by random dumps with random content, corruptions and lengths.
// Results are checked against an in-bench model of the stream checker while
// both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
  import bvde_pkg::*;

  typedef enum int {SUM_GOOD, SUM_FLIP, SUM_HIGH} sum_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic       has;
    out_t       beat;
  } row_t;

  typedef struct {
    in_t  beat;
    bit   typed;
    bit   typed_has;
    out_t typed_out;
  } feed_t;

  localparam out_t NO_BEAT   = '0;
  localparam out_t SIZE_BEAT = {1'b1, 8'h00, 7'd0, ST_SIZE};

  // Voice 0 is selected out of reset, so the first data bytes come straight out.
  localparam row_t DIRECTED [23] = '{
    {8'hF7, 1'b1, 1'b1, 1'b1, SIZE_BEAT},
    {8'h00, 1'b1, 1'b1, 1'b1, SIZE_BEAT},
    {8'hFF, 1'b0, 1'b1, 1'b0, NO_BEAT},
    {8'h43, 1'b0, 1'b1, 1'b0, NO_BEAT},
    {8'h00, 1'b0, 1'b1, 1'b0, NO_BEAT},
    {8'h09, 1'b0, 1'b1, 1'b0, NO_BEAT},
    {8'h80, 1'b0, 1'b1, 1'b0, NO_BEAT},
    {8'h7F, 1'b0, 1'b1, 1'b0, NO_BEAT},
    {8'hFF, 1'b0, 1'b1, 1'b1, {1'b0, 8'hFF, 7'd0, ST_OK}},
    {8'h00, 1'b0, 1'b1, 1'b1, {1'b0, 8'h00, 7'd1, ST_OK}},
    {8'h80, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h5A, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'hF7, 1'b1, 1'b1, 1'b1, SIZE_BEAT},
    {8'hF0, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h43, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h3C, 1'b1, 1'b1, 1'b1, SIZE_BEAT},
    {8'hF0, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h12, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h55, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h09, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h01, 1'b0, 1'b0, 1'b0, NO_BEAT},
    {8'h02, 1'b0, 1'b0, 1'b0, NO_BEAT},
    // flag on the first data byte: status only, no voice beat
    {8'h33, 1'b1, 1'b1, 1'b1, SIZE_BEAT}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  in_t              dump_in = '0;
  logic             full;
  logic             empty;
  logic             pop = 1'b0;
  out_t             result;
  logic             voice_select_we = 1'b0;
  logic [SEL_W-1:0] voice_select = '0;

  bulk_voice_dump_extractor_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .dump_in         (dump_in),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .result          (result),
    .voice_select_we (voice_select_we),
    .voice_select    (voice_select)
  );

  // stream checker model
  int unsigned      dump_pos;
  logic [6:0]       neg_sum = '0;
  logic [7:0]       check_byte = '0;
  bit               start_seen, vendor_seen, type_seen;
  logic [SEL_W-1:0] voice_sel = '0;

  feed_t byte_feed [$];
  out_t  pending_beats [$];

  bit   hold_send;
  bit   calm;
  int   gap_left;
  int   burst_left = 1;
  int   stall_left;
  logic [7:0] pop_mask;

  int   errors;
  int   bytes_taken;
  int   dumps_built;
  int   voice_beats;
  int   status_beats;
  logic [7:0] codes_seen = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic void track_byte(input in_t din, output bit has, output out_t beat);
    int unsigned idx;
    has  = 1'b0;
    beat = '0;
    if (din.final_byte) begin
      has = 1'b1;
      beat.is_status = 1'b1;
      if (dump_pos != END_POS)             beat.status_code = ST_SIZE;
      else if (!start_seen)                beat.status_code = ST_START;
      else if (!vendor_seen)               beat.status_code = ST_VENDOR;
      else if (din.dump_byte != EOX_BYTE)  beat.status_code = ST_END;
      else if (!type_seen)                 beat.status_code = ST_TYPE;
      else if (check_byte != {1'b0, neg_sum}) beat.status_code = ST_CHECKSUM;
      else                                 beat.status_code = ST_OK;
      dump_pos    = 0;
      neg_sum     = '0;
      check_byte  = '0;
      start_seen  = 1'b0;
      vendor_seen = 1'b0;
      type_seen   = 1'b0;
      return;
    end
    if (dump_pos == POS_START && din.dump_byte == SOX_BYTE)   start_seen = 1'b1;
    if (dump_pos == POS_VENDOR && din.dump_byte == VENDOR_BYTE) vendor_seen = 1'b1;
    if (dump_pos == POS_TYPE && din.dump_byte == TYPE_BYTE)   type_seen = 1'b1;
    if (dump_pos == CHECK_POS) check_byte = din.dump_byte;
    if (dump_pos >= HDR_LEN && dump_pos < CHECK_POS) begin
      idx     = dump_pos - HDR_LEN;
      neg_sum = neg_sum - din.dump_byte[6:0];
      if (idx / VOICE_BYTES == voice_sel) begin
        has               = 1'b1;
        beat.voice_byte   = din.dump_byte;
        beat.voice_offset = OFFSET_W'(idx % VOICE_BYTES);
      end
    end
    // hold at the saturation point
    if (dump_pos < POS_SAT) dump_pos++;
  endfunction

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] not_byte(logic [7:0] avoid);
    logic [7:0] b;
    do b = any_byte(); while (b == avoid);
    return b;
  endfunction

  function automatic void feed_byte(logic [7:0] b, logic last);
    feed_t f;
    f.beat.dump_byte  = b;
    f.beat.final_byte = last;
    f.typed           = 1'b0;
    f.typed_has       = 1'b0;
    f.typed_out       = '0;
    byte_feed.push_back(f);
  endfunction

  // Lay out one dump of len bytes, the last one flagged.
  task automatic queue_dump(input bit bad_start, bad_vendor, bad_type, bad_end,
                            input sum_mode_t sum_mode, input int len);
    logic [7:0] b;
    logic [6:0] sum;
    sum = '0;
    @(negedge clk);
    for (int p = 0; p < len; p++) begin
      b = any_byte();
      if (p == len - 1)            b = bad_end ? not_byte(EOX_BYTE) : EOX_BYTE;
      else if (p == POS_START)     b = bad_start ? not_byte(SOX_BYTE) : SOX_BYTE;
      else if (p == POS_VENDOR)    b = bad_vendor ? not_byte(VENDOR_BYTE) : VENDOR_BYTE;
      else if (p == POS_TYPE)      b = bad_type ? not_byte(TYPE_BYTE) : TYPE_BYTE;
      else if (p == CHECK_POS) begin
        case (sum_mode)
          SUM_FLIP: b = {1'b0, sum ^ 7'($urandom_range(1, 127))};
          SUM_HIGH: b = {1'b1, sum};
          default:  b = {1'b0, sum};
        endcase
      end else if (p >= HDR_LEN && p < CHECK_POS) begin
        sum = sum - b[6:0];
      end
      feed_byte(b, p == len - 1);
    end
    dumps_built++;
  endtask

  // Wait until every byte is taken and every beat has come out.
  task automatic drain();
    while (byte_feed.size() != 0 || push || pending_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_voice(input logic [SEL_W-1:0] v);
    @(posedge clk);
    voice_select_we <= 1'b1;
    voice_select    <= v;
    @(posedge clk);
    voice_select_we <= 1'b0;
    voice_sel = v;
  endtask

  always @(posedge clk) begin : feed_side
    feed_t cur;
    bit    has;
    out_t  want;
    logic  go;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        cur = byte_feed.pop_front();
        track_byte(cur.beat, has, want);
        if (cur.typed) begin
          has  = cur.typed_has;
          want = cur.typed_out;
        end
        if (has) pending_beats.push_back(want);
        bytes_taken++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 64);
          gap_left   = calm ? 0 : $urandom_range(0, 7);
        end
      end
      go = 1'b0;
      if (gap_left != 0) gap_left--;
      else go = byte_feed.size() != 0 && !hold_send;
      push <= go;
      if (go) dump_in <= byte_feed[0].beat;
    end
  end

  always @(posedge clk) begin : result_side
    out_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none got %p", $time, result);
        end else begin
          want = pending_beats.pop_front();
          cmp_field("is_status", 8'(want.is_status), 8'(result.is_status));
          cmp_field("voice_byte", want.voice_byte, result.voice_byte);
          cmp_field("voice_offset", 8'(want.voice_offset), 8'(result.voice_offset));
          cmp_field("status_code", 8'(want.status_code), 8'(result.status_code));
          if (want.is_status) begin
            status_beats++;
            codes_seen[want.status_code] = 1'b1;
          end else begin
            voice_beats++;
          end
        end
      end
      // rotate a random stall mask, reload it now and then
      if (stall_left == 0) begin
        pop_mask   = 8'($urandom) | 8'h01;
        stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      pop_mask = {pop_mask[0], pop_mask[7:1]};
      pop <= calm ? 1'b1 : pop_mask[0];
    end
  end

  initial begin : run
    feed_t     f;
    int        len;
    int        pick;
    sum_mode_t sm;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (DIRECTED[i]) begin
      f.beat.dump_byte  = DIRECTED[i].b;
      f.beat.final_byte = DIRECTED[i].last;
      f.typed           = DIRECTED[i].typed;
      f.typed_has       = DIRECTED[i].has;
      f.typed_out       = DIRECTED[i].beat;
      byte_feed.push_back(f);
    end

    // clean dump, last voice, paused inside its voice window
    drain();
    set_voice(5'd31);
    calm = 1'b1;
    queue_dump(1'b0, 1'b0, 1'b0, 1'b0, SUM_GOOD, DUMP_LEN);
    while (byte_feed.size() > 100) @(negedge clk);
    hold_send = 1'b1;
    while (push || pending_beats.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    hold_send = 1'b0;
    drain();
    calm = 1'b0;

    set_voice(5'd0);
    queue_dump(1'b1, 1'b0, 1'b0, 1'b0, SUM_GOOD, DUMP_LEN);
    drain();
    set_voice(5'($urandom));
    queue_dump(1'b0, 1'b1, 1'b0, 1'b0, SUM_GOOD, DUMP_LEN);
    queue_dump(1'b0, 1'b0, 1'b0, 1'b1, SUM_GOOD, DUMP_LEN);
    queue_dump(1'b0, 1'b0, 1'b1, 1'b0, SUM_GOOD, DUMP_LEN);
    drain();
    set_voice(5'($urandom));
    // checksum byte with its top bit set
    queue_dump(1'b0, 1'b0, 1'b0, 1'b0, SUM_HIGH, DUMP_LEN);
    // late flag: position saturates, size fails
    queue_dump(1'b0, 1'b0, 1'b0, 1'b0, SUM_GOOD, DUMP_LEN + 5);

    for (int d = 0; d < 8; d++) begin
      drain();
      if ($urandom_range(0, 2) != 0) set_voice(5'($urandom));
      calm = $urandom_range(0, 4) == 0;
      @(negedge clk);
      len = $urandom_range(0, 30);
      for (int k = 0; k < len; k++) feed_byte(8'($urandom), $urandom_range(0, 5) == 0);
      // end the noise on a flag so the dump starts clean
      feed_byte(8'($urandom), 1'b1);
      pick = $urandom_range(0, 9);
      sm   = sum_mode_t'($urandom_range(0, 2));
      if (pick < 5) begin
        queue_dump(1'b0, 1'b0, 1'b0, 1'b0, SUM_GOOD, DUMP_LEN);
      end else if (pick == 5) begin
        len = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, DUMP_LEN - 1);
        queue_dump(1'b0, 1'b0, 1'b0, 1'b0, sm, len);
      end else if (pick == 6) begin
        queue_dump(1'b0, 1'b0, 1'b0, 1'b0, sm, DUMP_LEN + $urandom_range(1, 40));
      end else begin
        queue_dump($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                   $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0, sm, DUMP_LEN);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (pending_beats.size() != 0) begin
      errors++;
      $display("%0t: %0d beats never came out", $time, pending_beats.size());
    end
    $display("Covered %0d bytes over %0d laid-out dumps plus noise: %0d voice, %0d status",
             bytes_taken, dumps_built, voice_beats, status_beats);
    $display("Status codes seen, one bit per code from ok upward: %b", codes_seen[6:0]);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
